// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the setpoint sequencer.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge while reset is low.
`define PSS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge while reset is low.
`define PSS_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/core/pss_pkg.sv
// Types and fixed constants of the setpoint sequencer.
// No dependencies; used by pss_serial and pid_setpoint_sequencer.
package pss_pkg;

   localparam int unsigned MUL_A_W = 32;                 // multiplier bits, one per step
   localparam int unsigned MUL_B_W = 48;                 // multiplicand bits
   localparam int unsigned DIV_N_W = 53;                 // dividend and quotient bits
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;  // full product bits
   localparam int unsigned CNT_W   = 6;

   localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
   localparam logic [CNT_W-1:0] DIV_LAST = 6'd52;

   // word kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_TIME   = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   // register map, word index
   localparam logic [2:0] REG_GAIN_P = 3'd0;
   localparam logic [2:0] REG_GAIN_I = 3'd1;
   localparam logic [2:0] REG_GAIN_D = 3'd2;
   localparam logic [2:0] REG_LIMIT  = 3'd3;
   localparam logic [2:0] REG_PERIOD = 3'd4;
   localparam logic [2:0] REG_HOLD_T = 3'd5;
   localparam logic [2:0] REG_COUNT  = 3'd6;
   localparam logic [2:0] REG_BAND   = 3'd7;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] measurement;
      logic [31:0]        now_ms;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               updated;
      logic [3:0]         target_index;
      logic               holding;
      logic               finished;
   } rsp_word_type;

   typedef struct packed {
      logic               start;
      logic               is_div;
      logic [DIV_N_W-1:0] op_a;
      logic [MUL_B_W-1:0] op_b;
   } ser_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] result;
   } ser_sts_type;

endpackage

// File: rtl/core/pid_setpoint_sequencer.sv
// A sample word that updates the output uses the bit-serial unit for four multiplies
// and one or two divides; one gated by the sample period uses none. Table, time and
// spare words go straight to emit. Throughput: one word at a time, accepted the cycle
// after the previous result is loaded. Reset (synchronous, active high) clears the
// sequencer and PID state and sets the configuration defaults; the table is undefined.
// Depends on pss_pkg, pss_ram, pss_serial and assert_macros.svh.
`include "assert_macros.svh"

module pid_setpoint_sequencer #(
   parameter int TABLE_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pss_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pss_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int U_W = 22 + FRAC_BITS;   // width of 95 * limit * 2^F / 100
   localparam logic [8:0]  DEPTH_W  = 9'(TABLE_DEPTH);
   localparam logic [54:0] RND_MASK = (55'd1 << FRAC_BITS) - 55'd1;
   localparam logic signed [64:0] IMAX = 65'sh7FFF_FFFF_FFFF;
   localparam logic signed [64:0] IMIN = -65'sh7FFF_FFFF_FFFF;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ERR   = 4'd1;
   localparam logic [3:0] S_MAG   = 4'd2;
   localparam logic [3:0] S_HOLD  = 4'd3;
   localparam logic [3:0] S_INC   = 4'd4;
   localparam logic [3:0] S_INTEG = 4'd5;
   localparam logic [3:0] S_PMUL  = 4'd6;
   localparam logic [3:0] S_IMUL  = 4'd7;
   localparam logic [3:0] S_DMUL  = 4'd8;
   localparam logic [3:0] S_DDIV  = 4'd9;
   localparam logic [3:0] S_UDIV  = 4'd10;
   localparam logic [3:0] S_SUM   = 4'd11;
   localparam logic [3:0] S_CLAMP = 4'd12;
   localparam logic [3:0] S_EMIT  = 4'd13;

   // configuration registers
   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [14:0] limit_ff;
   logic [15:0] period_ff;
   logic [31:0] hold_time_ff;
   logic [4:0]  count_ff;
   logic [30:0] band_ff;

   // sequencer and PID state
   logic [3:0]  state_ff;
   logic [3:0]  tpos_ff;
   logic        hold_ff;
   logic [31:0] hold_start_ff;
   logic        done_ff;
   logic [31:0] last_time_ff;
   logic [31:0] last_err_ff;
   logic [47:0] integ_ff;
   logic [15:0] drive_ff;
   logic        rsp_valid_ff;
   pss_pkg::rsp_word_type rsp_ff;

   // per-word working registers
   logic [31:0] meas_ff, now_ff;
   logic        upd_ff;
   logic [31:0] e_ff, emag_ff, elapsed_ff, dt_ff;
   logic [32:0] de_ff, demag_ff;
   logic [63:0] inc_ff;
   logic [47:0] integ_new_ff;
   logic [52:0] p_ff, i_ff, d_ff;
   logic        tsign_ff;
   logic [U_W-1:0]     u_ff;
   logic signed [54:0] s_ff;

   // next values of the hold logic
   logic [3:0]  tpos_in;
   logic        hold_in, hold_mid, done_in;
   logic [31:0] hold_start_in;

   logic        accept, cfg_wr;
   logic [8:0]  pos_wide, idx_wide, cnt_eff;
   logic [31:0] ram_rdata, sp;
   logic [32:0] diff33;
   logic [31:0] e_sat;
   logic        out_band, in_band, expired, can_adv, dt_low, dt_zero;
   logic signed [64:0] isum;
   logic [47:0] imag;
   logic [21:0] l95;
   logic [52:0] udiv_n;
   logic signed [54:0] upper, lower, s_adj, s_shr;
   logic [54:0] lim_sh;
   logic [U_W-1:0] u_shr;
   logic        clamp_hi, clamp_lo;
   logic        in_emit, unit_wait;

   pss_pkg::ser_ctl_type ctl;
   pss_pkg::ser_sts_type sts;

   function automatic logic [31:0] gmag(input logic [31:0] g);
      return g[31] ? (32'd0 - g) : g;
   endfunction

   // product scaled by 2^-F, saturated to the term bound
   function automatic logic [51:0] sat_mag(input logic [pss_pkg::PROD_W-1:0] prod);
      logic [pss_pkg::PROD_W-1:0] shr;
      shr = prod >> FRAC_BITS;
      return (|shr[pss_pkg::PROD_W-1:52]) ? {52{1'b1}} : shr[51:0];
   endfunction

   function automatic logic [52:0] apply_sign(input logic [51:0] m, input logic neg);
      return neg ? (53'd0 - {1'b0, m}) : {1'b0, m};
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;

   // ---------------- setpoint table ----------------
   // Read at the current position every cycle; the word accepted in idle sees
   // the registered data in S_ERR, the cycle after. Positions outside the table read zero.
   assign pos_wide = {5'd0, tpos_ff};
   assign idx_wide = {5'd0, req_word.entry_index};

   pss_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (accept && (req_word.kind == pss_pkg::KIND_LOAD) && (idx_wide < DEPTH_W)),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data (req_word.entry_value),
      .rd_addr (pos_wide[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign sp = (pos_wide < DEPTH_W) ? ram_rdata : 32'd0;

   // error, saturated to 32 bits
   assign diff33 = {sp[31], sp} - {meas_ff[31], meas_ff};
   assign e_sat  = (diff33[32] != diff33[31]) ?
                   (diff33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : diff33[31:0];

   // ---------------- hold and advance ----------------
   assign out_band = emag_ff > {1'b0, band_ff};
   assign in_band  = emag_ff < {1'b0, band_ff};
   assign expired  = elapsed_ff > hold_time_ff;
   assign cnt_eff  = ({4'd0, count_ff} > DEPTH_W) ? DEPTH_W : {4'd0, count_ff};
   assign can_adv  = (pos_wide + 9'd1) < cnt_eff;
   assign dt_low   = dt_ff < {16'd0, period_ff};
   assign dt_zero  = (dt_ff == 32'd0);

   always_comb begin
      tpos_in       = tpos_ff;
      done_in       = done_ff;
      hold_start_in = hold_start_ff;
      hold_mid      = hold_ff;
      if (hold_ff) begin
         // leaving the band restarts the clock; otherwise a long hold completes
         priority if (out_band) begin
            hold_start_in = now_ff;
            hold_mid      = 1'b0;
         end else if (expired) begin
            if (can_adv) begin
               tpos_in = tpos_ff + 4'd1;
            end else begin
               done_in = 1'b1;
            end
            hold_mid = 1'b0;
         end
      end
      if (!hold_mid && in_band) begin
         hold_in       = 1'b1;
         hold_start_in = now_ff;
      end else begin
         hold_in = hold_mid;
      end
   end

   // ---------------- PID arithmetic ----------------
   assign isum = $signed({{17{integ_ff[47]}}, integ_ff}) + $signed({inc_ff[63], inc_ff});
   assign imag = integ_new_ff[47] ? (48'd0 - integ_new_ff) : integ_new_ff;
   assign l95    = 22'(limit_ff) * 22'd95;
   assign udiv_n = 53'(l95) << FRAC_BITS;

   assign upper    = $signed(55'(u_ff));
   assign lim_sh   = 55'(limit_ff) << FRAC_BITS;
   assign lower    = -$signed(lim_sh);
   assign clamp_hi = s_ff >= upper;
   assign clamp_lo = s_ff <= lower;
   assign u_shr    = u_ff >> FRAC_BITS;
   // truncate toward zero: bias negatives before the arithmetic shift
   assign s_adj    = s_ff + $signed(s_ff[54] ? RND_MASK : 55'd0);
   assign s_shr    = s_adj >>> FRAC_BITS;

   // ---------------- serial unit requests ----------------
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_HOLD: begin
            if (!dt_low) begin
               ctl.start = 1'b1;
               ctl.op_a  = 53'(emag_ff);
               ctl.op_b  = 48'(dt_ff);
            end
         end
         S_INTEG: begin
            ctl.start = 1'b1;
            ctl.op_a  = 53'(gmag(gain_p_ff));
            ctl.op_b  = 48'(emag_ff);
         end
         S_PMUL: begin
            if (sts.done) begin
               ctl.start = 1'b1;
               ctl.op_a  = 53'(gmag(gain_i_ff));
               ctl.op_b  = imag;
            end
         end
         S_IMUL: begin
            if (sts.done) begin
               ctl.start = 1'b1;
               ctl.op_a  = 53'(gmag(gain_d_ff));
               ctl.op_b  = 48'(demag_ff);
            end
         end
         S_DMUL: begin
            if (sts.done) begin
               ctl.start  = 1'b1;
               ctl.is_div = 1'b1;
               if (dt_zero) begin
                  ctl.op_a = udiv_n;
                  ctl.op_b = 48'd100;
               end else begin
                  ctl.op_a = {1'b0, sat_mag(sts.result)};
                  ctl.op_b = 48'(dt_ff);
               end
            end
         end
         S_DDIV: begin
            if (sts.done) begin
               ctl.start  = 1'b1;
               ctl.is_div = 1'b1;
               ctl.op_a   = udiv_n;
               ctl.op_b   = 48'd100;
            end
         end
         default: begin
         end
      endcase
   end

   pss_serial u_serial (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   // ---------------- control and architectural state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         tpos_ff       <= 4'd0;
         hold_ff       <= 1'b0;
         hold_start_ff <= 32'd0;
         done_ff       <= 1'b0;
         last_time_ff  <= 32'd0;
         last_err_ff   <= 32'd0;
         integ_ff      <= 48'd0;
         drive_ff      <= 16'd0;
         gain_p_ff     <= 32'd0;
         gain_i_ff     <= 32'd0;
         gain_d_ff     <= 32'd0;
         limit_ff      <= 15'd0;
         period_ff     <= 16'd0;
         hold_time_ff  <= 32'd30000;
         count_ff      <= 5'd1;
         band_ff       <= 31'd19661;
      end else begin
         if (cfg_wr) begin
            unique case (paddr[4:2])
               pss_pkg::REG_GAIN_P: gain_p_ff    <= pwdata;
               pss_pkg::REG_GAIN_I: gain_i_ff    <= pwdata;
               pss_pkg::REG_GAIN_D: gain_d_ff    <= pwdata;
               pss_pkg::REG_LIMIT:  limit_ff     <= pwdata[14:0];
               pss_pkg::REG_PERIOD: period_ff    <= pwdata[15:0];
               pss_pkg::REG_HOLD_T: hold_time_ff <= pwdata;
               pss_pkg::REG_COUNT:  count_ff     <= pwdata[4:0];
               pss_pkg::REG_BAND:   band_ff      <= pwdata[30:0];
            endcase
         end

         // drop the result once taken; in emit a taken result is replaced instead
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_word.kind)
                     pss_pkg::KIND_SAMPLE: state_ff <= S_ERR;
                     pss_pkg::KIND_TIME: begin
                        last_time_ff <= req_word.now_ms;
                        state_ff     <= S_EMIT;
                     end
                     pss_pkg::KIND_LOAD: state_ff <= S_EMIT;
                     default:            state_ff <= S_EMIT;
                  endcase
               end
            end
            S_ERR: state_ff <= S_MAG;
            S_MAG: state_ff <= S_HOLD;
            S_HOLD: begin
               tpos_ff       <= tpos_in;
               hold_ff       <= hold_in;
               hold_start_ff <= hold_start_in;
               done_ff       <= done_in;
               // too soon since the last update: report status only
               state_ff      <= dt_low ? S_EMIT : S_INC;
            end
            S_INC:   if (sts.done) state_ff <= S_INTEG;
            S_INTEG: state_ff <= S_PMUL;
            S_PMUL:  if (sts.done) state_ff <= S_IMUL;
            S_IMUL:  if (sts.done) state_ff <= S_DMUL;
            S_DMUL:  if (sts.done) state_ff <= dt_zero ? S_UDIV : S_DDIV;
            S_DDIV:  if (sts.done) state_ff <= S_UDIV;
            S_UDIV:  if (sts.done) state_ff <= S_SUM;
            S_SUM:   state_ff <= S_CLAMP;
            S_CLAMP: begin
               // clamping at either bound discards this update's integral step
               priority if (clamp_hi) begin
                  drive_ff <= u_shr[15:0];
               end else if (clamp_lo) begin
                  drive_ff <= 16'd0 - {1'b0, limit_ff};
               end else begin
                  drive_ff <= s_shr[15:0];
                  integ_ff <= integ_new_ff;
               end
               last_err_ff  <= e_ff;
               last_time_ff <= now_ff;
               state_ff     <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- working registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         meas_ff <= req_word.measurement;
         now_ff  <= req_word.now_ms;
         upd_ff  <= 1'b0;
      end
      unique case (state_ff)
         S_ERR: e_ff <= e_sat;
         S_MAG: begin
            emag_ff    <= gmag(e_ff);
            elapsed_ff <= now_ff - hold_start_ff;
            dt_ff      <= now_ff - last_time_ff;
            de_ff      <= {e_ff[31], e_ff} - {last_err_ff[31], last_err_ff};
         end
         S_HOLD: demag_ff <= de_ff[32] ? (33'd0 - de_ff) : de_ff;
         S_INC: begin
            if (sts.done) begin
               inc_ff <= e_ff[31] ? (64'd0 - {1'b0, sts.result[62:0]})
                                  : {1'b0, sts.result[62:0]};
            end
         end
         S_INTEG: begin
            priority if (isum > IMAX) begin
               integ_new_ff <= IMAX[47:0];
            end else if (isum < IMIN) begin
               integ_new_ff <= IMIN[47:0];
            end else begin
               integ_new_ff <= isum[47:0];
            end
         end
         S_PMUL: begin
            if (sts.done) p_ff <= apply_sign(sat_mag(sts.result), gain_p_ff[31] ^ e_ff[31]);
         end
         S_IMUL: begin
            if (sts.done) begin
               i_ff <= apply_sign(sat_mag(sts.result), gain_i_ff[31] ^ integ_new_ff[47]);
            end
         end
         S_DMUL: begin
            if (sts.done) begin
               tsign_ff <= gain_d_ff[31] ^ de_ff[32];
               if (dt_zero) d_ff <= 53'd0;
            end
         end
         S_DDIV: if (sts.done) d_ff <= apply_sign(sts.result[51:0], tsign_ff);
         S_UDIV: if (sts.done) u_ff <= sts.result[U_W-1:0];
         S_SUM: begin
            s_ff <= $signed({{2{p_ff[52]}}, p_ff}) + $signed({{2{i_ff[52]}}, i_ff})
                  + $signed({{2{d_ff[52]}}, d_ff});
         end
         S_CLAMP: upd_ff <= 1'b1;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff.drive        <= drive_ff;
               rsp_ff.updated      <= upd_ff;
               rsp_ff.target_index <= tpos_ff;
               rsp_ff.holding      <= hold_ff;
               rsp_ff.finished     <= done_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // ---------------- register read ----------------
   always_comb begin
      unique case (paddr[4:2])
         pss_pkg::REG_GAIN_P: prdata = gain_p_ff;
         pss_pkg::REG_GAIN_I: prdata = gain_i_ff;
         pss_pkg::REG_GAIN_D: prdata = gain_d_ff;
         pss_pkg::REG_LIMIT:  prdata = 32'(limit_ff);
         pss_pkg::REG_PERIOD: prdata = 32'(period_ff);
         pss_pkg::REG_HOLD_T: prdata = hold_time_ff;
         pss_pkg::REG_COUNT:  prdata = 32'(count_ff);
         pss_pkg::REG_BAND:   prdata = 32'(band_ff);
      endcase
   end

   // ---------------- assertions ----------------
   // the emit state, and the states that wait on the serial unit
   assign in_emit   = (state_ff == S_EMIT);
   assign unit_wait = (state_ff == S_INC) || (state_ff == S_PMUL) || (state_ff == S_IMUL) ||
                      (state_ff == S_DMUL) || (state_ff == S_DDIV) || (state_ff == S_UDIV);

   `PSS_ASSERT(a_done_sticky, clock, reset, done_ff |=> done_ff, "finished dropped")
   `PSS_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(in_emit), "early rsp")
   `PSS_ASSERT(a_unit_done_waited, clock, reset, sts.done |-> unit_wait, "unit done unawaited")
   `PSS_ASSERT_NEVER(a_ready_busy, clock, reset, req_ready && sts.busy, "input while busy")

endmodule

// File: rtl/core/pss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pss_serial.sv
// Bit-serial unsigned multiplier (one multiplier bit per cycle) and restoring
// divider (one quotient bit per cycle). Depends on pss_pkg.
module pss_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  pss_pkg::ser_ctl_type  ctl,
   output pss_pkg::ser_sts_type  sts
);

   logic                         busy_ff;
   logic                         done_ff;
   logic                         div_ff;
   logic [pss_pkg::CNT_W-1:0]    cnt_ff;
   logic [pss_pkg::MUL_B_W-1:0]  acc_ff;
   logic [pss_pkg::MUL_A_W-1:0]  lo_ff;
   logic [pss_pkg::DIV_N_W-1:0]  sh_ff;
   logic [pss_pkg::MUL_B_W-1:0]  opb_ff;

   logic [48:0] mul_sum;
   logic [32:0] div_r2;
   logic [33:0] div_diff;
   logic        div_ge;
   logic        last_step;

   // multiply: add the multiplicand when the low multiplier bit is set, shift right
   assign mul_sum  = {1'b0, acc_ff} + (sh_ff[0] ? {1'b0, opb_ff} : 49'd0);
   // divide: bring down the next dividend bit, subtract when it fits
   assign div_r2   = {acc_ff[31:0], sh_ff[52]};
   assign div_diff = {1'b0, div_r2} - {2'b00, opb_ff[31:0]};
   assign div_ge   = !div_diff[33];
   assign last_step = (cnt_ff == (div_ff ? pss_pkg::DIV_LAST : pss_pkg::MUL_LAST));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            div_ff  <= ctl.is_div;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         acc_ff <= '0;
         lo_ff  <= '0;
         sh_ff  <= ctl.op_a;
         opb_ff <= ctl.op_b;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_ff <= {15'd0, (div_ge ? div_diff[32:0] : div_r2)};
            sh_ff  <= {sh_ff[51:0], div_ge};
         end else begin
            acc_ff <= mul_sum[48:1];
            lo_ff  <= {mul_sum[0], lo_ff[31:1]};
            sh_ff  <= sh_ff >> 1;
         end
      end
   end

   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;
   assign sts.result = div_ff ? {27'd0, sh_ff} : {acc_ff, lo_ff};

endmodule
